// ===== rtl/phkr_pkg.sv =====
// ----------------------------------------------------------------------------
// phkr_pkg: shared types and constants for the pose history ring
// Holds the pose record, the mode and register codes and the cell operations.
// ----------------------------------------------------------------------------
package phkr_pkg;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] h;
    logic        [51:0] t;
  } pose_t;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t CELL_HOLD = 2'd0;
  localparam cell_op_t CELL_LOAD = 2'd1;
  localparam cell_op_t CELL_ROT  = 2'd2;

  localparam logic [1:0] MODE_OFFER   = 2'd0;
  localparam logic [1:0] MODE_BRACKET = 2'd1;
  localparam logic [1:0] MODE_FIND    = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [1:0] REG_DIST    = 2'd0;
  localparam logic [1:0] REG_HEADING = 2'd1;
  localparam logic [1:0] REG_TIME    = 2'd2;

  localparam logic [51:0] ONE_SECOND_US = 52'd1000000;
  localparam int unsigned MIN_ENTRIES = 3;

endpackage

// ===== rtl/phkr_cell.sv =====
// ----------------------------------------------------------------------------
// phkr_cell: one pose slot of the history chain
// Holds a pose, loads from its younger neighbor or rotates from its older one.
// ----------------------------------------------------------------------------
module phkr_cell (
  input  logic               clk,
  input  phkr_pkg::cell_op_t op,
  input  phkr_pkg::pose_t    lower,
  input  phkr_pkg::pose_t    upper,
  output phkr_pkg::pose_t    pose
);
  import phkr_pkg::*;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LOAD: pose <= lower;
      CELL_ROT:  pose <= upper;
      default:   pose <= pose;
    endcase
  end

endmodule

// ===== rtl/pose_history_keyframe_ring_unit.sv =====
// ----------------------------------------------------------------------------
// pose_history_keyframe_ring_unit: keyframe ring of robot poses
// Stores keyframe poses in a chain of cells ordered by age and answers
// time-bracket and distance queries by rotating the chain past its head.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time. An offer goes from acceptance
// through the squared distance products and the decision to the load of the
// output register. A clear and the quick answers (empty ring, query newer
// than the newest keyframe) go from the products step straight to the
// output register. A time bracket or distance search that has to walk the
// history lasts for the full rotation of the cell chain, which moves one
// pose past the head cell per cycle and must come back to its original
// order; when the ring is full and the walk runs to its last step, the
// newest keyframe, the walk also waits for that final test. A finished
// result waits in the output register until taken, and a new transaction is
// accepted once the result is handed over to that register.
module pose_history_keyframe_ring_unit #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic signed [23:0]  pose_x,
  input  logic signed [23:0]  pose_y,
  input  logic signed [15:0]  pose_heading,
  input  logic [51:0]         pose_time,
  input  logic [51:0]         query_time,
  input  logic [23:0]         distance_limit,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                accepted,
  output logic                found,
  output logic signed [23:0]  before_x,
  output logic signed [23:0]  before_y,
  output logic signed [15:0]  before_heading,
  output logic [51:0]         before_time,
  output logic signed [23:0]  after_x,
  output logic signed [23:0]  after_y,
  output logic signed [15:0]  after_heading,
  output logic [51:0]         after_time
);
  import phkr_pkg::*;

  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_OFFER = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state;

  // Threshold registers.
  logic [23:0] min_dist;
  logic [15:0] min_head;
  logic [31:0] min_time;

  // Latched transaction.
  logic [1:0]  in_mode;
  pose_t       in_pose;
  logic [51:0] in_q;
  logic [23:0] in_dl;

  // Ring state: the cell chain is ordered by age, cell 0 holds the newest.
  pose_t       cell_q [HISTORY_DEPTH];
  cell_op_t    cell_op;
  logic [CW-1:0] cnt;
  pose_t       latest;

  // Walk state.
  pose_t       head;
  pose_t       prev;
  pose_t       st1;
  logic        st1_v;
  logic        st1_last;
  logic [CW-1:0] step;
  logic        decided;

  // Shared product stage.
  logic [49:0] sqx;
  logic [49:0] sqy;
  logic [47:0] limsq;

  // Result staging and output register.
  logic  res_acc;
  logic  res_found;
  pose_t res_before;
  pose_t res_after;
  logic  o_acc;
  logic  o_found;
  pose_t o_before;
  pose_t o_after;

  pose_t cell0;
  assign cell0 = cell_q[0];

  genvar gi;
  generate
    for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
      pose_t lower_in;
      pose_t upper_in;
      if (gi == 0) begin : g_first
        assign lower_in = in_pose;
      end else begin : g_mid
        assign lower_in = cell_q[gi-1];
      end
      if (gi == HISTORY_DEPTH - 1) begin : g_last
        assign upper_in = cell_q[0];
      end else begin : g_up
        assign upper_in = cell_q[gi+1];
      end
      phkr_cell u_cell (
        .clk   (clk),
        .op    (cell_op),
        .lower (lower_in),
        .upper (upper_in),
        .pose  (cell_q[gi])
      );
    end
  endgenerate

  // During the walk, step k looks at the entry k keyframes older than the
  // newest; the final step looks at the newest itself, kept in head.
  logic  issue;
  pose_t cand;
  assign issue = (state == ST_WALK) && (step != '0) && (step <= cnt);
  assign cand  = (step == cnt) ? head : cell0;

  pose_t sq_b;
  logic signed [24:0] dx;
  logic signed [24:0] dy;
  logic signed [49:0] dx2;
  logic signed [49:0] dy2;
  logic [23:0] lim_in;
  assign sq_b   = (state == ST_WALK) ? cand : cell0;
  assign dx     = $signed({in_pose.x[23], in_pose.x}) - $signed({sq_b.x[23], sq_b.x});
  assign dy     = $signed({in_pose.y[23], in_pose.y}) - $signed({sq_b.y[23], sq_b.y});
  assign dx2    = dx * dx;
  assign dy2    = dy * dy;
  assign lim_in = (in_mode == MODE_OFFER) ? min_dist : in_dl;

  // Offer decision against the newest keyframe.
  logic [50:0] dsum;
  logic [15:0] dh;
  logic [15:0] adh;
  logic [51:0] dt;
  logic        t_ok;
  logic        store;
  assign dsum  = {1'b0, sqx} + {1'b0, sqy};
  assign dh    = in_pose.h - cell0.h;
  assign adh   = dh[15] ? (16'd0 - dh) : dh;
  assign dt    = in_pose.t - cell0.t;
  assign t_ok  = in_pose.t >= ONE_SECOND_US;
  assign store = t_ok && ((cnt < CW'(MIN_ENTRIES)) || (dsum > {3'b0, limsq}) ||
                          (adh > min_head) ||
                          ((in_pose.t > cell0.t) && (dt > {20'b0, min_time})));

  // Walk hit test on the registered candidate.
  logic hit;
  assign hit = (in_mode == MODE_BRACKET) ? (st1.t < in_q) : (dsum > {3'b0, limsq});

  // The answer is settled once a decision was taken or is being taken now.
  logic walk_done;
  assign walk_done = decided || (st1_v && (hit || st1_last));

  always_comb begin
    cell_op = CELL_HOLD;
    if (state == ST_OFFER && store) begin
      cell_op = CELL_LOAD;
    end else if (state == ST_WALK && step < DEPTH_C) begin
      cell_op = CELL_ROT;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      min_dist <= 24'd30;
      min_head <= 16'd182;
      min_time <= 32'd10000000;
      cnt      <= '0;
      latest   <= '0;
      out_valid <= 1'b0;
      st1_v    <= 1'b0;
      decided  <= 1'b0;
      step     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DIST:    min_dist <= cfg_data[23:0];
          REG_HEADING: min_head <= cfg_data[15:0];
          REG_TIME:    min_time <= cfg_data;
          default:     ;
        endcase
      end
      // In the finishing state the output register is handled below.
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            in_mode   <= mode;
            in_pose.x <= pose_x;
            in_pose.y <= pose_y;
            in_pose.h <= pose_heading;
            in_pose.t <= pose_time;
            in_q      <= query_time;
            in_dl     <= distance_limit;
            state     <= ST_PREP;
          end
        end
        ST_PREP: begin
          sqx        <= 50'(unsigned'(dx2));
          sqy        <= 50'(unsigned'(dy2));
          limsq      <= lim_in * lim_in;
          res_acc    <= 1'b0;
          res_found  <= 1'b0;
          res_before <= '0;
          res_after  <= '0;
          head       <= cell0;
          prev       <= cell0;
          step       <= '0;
          st1_v      <= 1'b0;
          decided    <= 1'b0;
          unique case (in_mode)
            MODE_OFFER: state <= ST_OFFER;
            MODE_CLEAR: begin
              cnt   <= '0;
              state <= ST_FIN;
            end
            MODE_BRACKET: begin
              if (cnt == '0) begin
                res_before <= latest;
                res_after  <= latest;
                res_found  <= 1'b1;
                state      <= ST_FIN;
              end else if (in_q > cell0.t) begin
                res_before <= (in_q > latest.t) ? latest : cell0;
                res_after  <= latest;
                res_found  <= 1'b1;
                state      <= ST_FIN;
              end else begin
                state <= ST_WALK;
              end
            end
            default: begin
              state <= (cnt == '0) ? ST_FIN : ST_WALK;
            end
          endcase
        end
        ST_OFFER: begin
          res_acc <= store;
          if (store && cnt < DEPTH_C) begin
            cnt <= cnt + 1'b1;
          end
          if (t_ok) begin
            latest <= in_pose;
          end
          state <= ST_FIN;
        end
        ST_WALK: begin
          if (step < DEPTH_C) begin
            step <= step + 1'b1;
          end
          st1_v <= issue;
          if (issue) begin
            st1      <= cand;
            st1_last <= (step == cnt);
            sqx      <= 50'(unsigned'(dx2));
            sqy      <= 50'(unsigned'(dy2));
          end
          if (st1_v && !decided) begin
            if (hit) begin
              res_before <= st1;
              res_after  <= prev;
              res_found  <= 1'b1;
              decided    <= 1'b1;
            end else if (st1_last) begin
              // Nothing qualified: report the oldest keyframe on both sides.
              res_before <= prev;
              res_after  <= prev;
              decided    <= 1'b1;
            end else begin
              prev <= st1;
            end
          end
          if (step == DEPTH_C && walk_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            o_acc     <= res_acc;
            o_found   <= res_found;
            o_before  <= res_before;
            o_after   <= res_after;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign accepted       = o_acc;
  assign found          = o_found;
  assign before_x       = o_before.x;
  assign before_y       = o_before.y;
  assign before_heading = o_before.h;
  assign before_time    = o_before.t;
  assign after_x        = o_after.x;
  assign after_y        = o_after.y;
  assign after_heading  = o_after.h;
  assign after_time     = o_after.t;

  // The fill count never passes the ring depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= DEPTH_C)
    else $error("entry count beyond ring depth");

  // An offer result never reports a query hit at the same time.
  a_acc_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && found))
    else $error("accepted and found both set");

  // A walk always ends with the chain back in order, after the full rotation.
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) ##1 (state == ST_FIN) |-> $past(step) == DEPTH_C)
    else $error("walk left before full rotation");

endmodule

// ===== bench/pose_ring_checker.sv =====
// ----------------------------------------------------------------------------
// pose_ring_checker: prediction and comparison for the pose history ring
// Watches the command, register and result channels, keeps its own copy of
// the ring and the thresholds, and compares every result with the oldest
// predicted answer.
// ----------------------------------------------------------------------------
module pose_ring_checker #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [23:0] pose_x,
  input  logic signed [23:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  logic [51:0]        pose_time,
  input  logic [51:0]        query_time,
  input  logic [23:0]        distance_limit,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               accepted,
  input  logic               found,
  input  phkr_pkg::pose_t    before_pose,
  input  phkr_pkg::pose_t    after_pose,
  output int                 fail_count,
  output int                 pending_count
);
  import phkr_pkg::*;

  typedef struct packed {
    logic  acc;
    logic  fnd;
    pose_t bef;
    pose_t aft;
  } answer_t;

  answer_t answer_queue[$];
  pose_t   ring[DEPTH];
  int      newest;
  int      count;
  pose_t   latest;
  logic [23:0] thr_dist;
  logic [15:0] thr_head;
  logic [31:0] thr_time;

  function automatic logic [63:0] dist_sq(logic signed [23:0] ax, logic signed [23:0] ay,
                                          logic signed [23:0] bx, logic signed [23:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return dx * dx + dy * dy;
  endfunction

  function automatic int prev_slot(int s);
    return (s == 0) ? count - 1 : s - 1;
  endfunction

  // Applies one command to the model state and returns the expected answer.
  function automatic answer_t predict_answer(logic [1:0] m, pose_t p, logic [51:0] q,
                                             logic [23:0] lim_mm);
    answer_t a;
    pose_t o;
    logic [15:0] dh, adh;
    longint dt;
    logic [63:0] lim;
    int cur, nxt;
    a = '0;
    if (m == MODE_OFFER) begin
      if (p.t >= ONE_SECOND_US) begin
        if (count < MIN_ENTRIES) begin
          a.acc = 1'b1;
        end else begin
          o = ring[newest];
          dh = p.h - o.h;
          adh = (dh >= 16'h8000) ? 16'(17'h10000 - dh) : dh;
          dt = longint'(p.t) - longint'(o.t);
          lim = 64'(thr_dist) * 64'(thr_dist);
          if (dist_sq(p.x, p.y, o.x, o.y) > lim || adh > thr_head ||
              dt > longint'(thr_time)) a.acc = 1'b1;
        end
        if (a.acc) begin
          newest = (newest + 1) % DEPTH;
          if (newest >= count) count++;
          ring[newest] = p;
        end
        latest = p;
      end
    end else if (m == MODE_CLEAR) begin
      newest = DEPTH - 1;
      count = 0;
    end else if (m == MODE_BRACKET) begin
      if (count == 0) begin
        a.bef = latest;
        a.aft = latest;
        a.fnd = 1'b1;
      end else if (q > ring[newest].t) begin
        a.bef = (q > latest.t) ? latest : ring[newest];
        a.aft = latest;
        a.fnd = 1'b1;
      end else begin
        cur = newest;
        nxt = cur;
        for (int i = 0; i < count && !a.fnd; i++) begin
          nxt = cur;
          cur = prev_slot(cur);
          a.fnd = ring[cur].t < q;
        end
        a.aft = ring[nxt];
        a.bef = a.fnd ? ring[cur] : ring[nxt];
      end
    end else if (count > 0) begin
      lim = 64'(lim_mm) * 64'(lim_mm);
      cur = newest;
      nxt = cur;
      for (int i = 0; i < count && !a.fnd; i++) begin
        nxt = cur;
        cur = prev_slot(cur);
        a.fnd = dist_sq(p.x, p.y, ring[cur].x, ring[cur].y) > lim;
      end
      a.aft = ring[nxt];
      a.bef = a.fnd ? ring[cur] : ring[nxt];
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t e, g;
    if (rst) begin
      newest = DEPTH - 1;
      count = 0;
      latest = '0;
      thr_dist = 24'd30;
      thr_head = 16'd182;
      thr_time = 32'd10000000;
      fail_count = 0;
      answer_queue.delete();
      pending_count = 0;
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIST:    thr_dist = cfg_data[23:0];
          REG_HEADING: thr_head = cfg_data[15:0];
          REG_TIME:    thr_time = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        g = {accepted, found, before_pose, after_pose};
        if (answer_queue.size() == 0) begin
          $display("%0t: result with no command waiting, actual %h", $time, g);
          fail_count = fail_count + 1;
        end else begin
          e = answer_queue.pop_front();
          if (e !== g) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, e, g);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        answer_queue.push_back(predict_answer(mode,
            '{pose_x, pose_y, pose_heading, pose_time}, query_time, distance_limit));
      pending_count = answer_queue.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the pose history ring
// Drives directed and random commands and register writes with random gaps
// and result stalls, while a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import phkr_pkg::*;

  localparam int DEPTH = 64;
  // Allow a wide margin over the longest walk, the gaps and the stalls.
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [1:0] mode;
  logic signed [23:0] pose_x, pose_y;
  logic signed [15:0] pose_heading;
  logic [51:0] pose_time, query_time;
  logic [23:0] distance_limit;
  logic out_valid, out_ready;
  logic accepted, found;
  pose_t before_pose, after_pose;
  int fail_count, pending_count;
  int idle_cycles;

  // Keeps the random pose stream near real robot motion so that offers are
  // sometimes stored and sometimes dropped, and queries land inside the ring.
  logic [51:0] track_time;
  logic signed [23:0] track_x, track_y;
  logic signed [15:0] track_heading;

  pose_history_keyframe_ring_unit #(.HISTORY_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .pose_x(pose_x), .pose_y(pose_y),
    .pose_heading(pose_heading), .pose_time(pose_time),
    .query_time(query_time), .distance_limit(distance_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .found(found),
    .before_x(before_pose.x), .before_y(before_pose.y),
    .before_heading(before_pose.h), .before_time(before_pose.t),
    .after_x(after_pose.x), .after_y(after_pose.y),
    .after_heading(after_pose.h), .after_time(after_pose.t)
  );

  pose_ring_checker #(.DEPTH(DEPTH)) i_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .pose_x(pose_x), .pose_y(pose_y),
    .pose_heading(pose_heading), .pose_time(pose_time),
    .query_time(query_time), .distance_limit(distance_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .found(found),
    .before_pose(before_pose), .after_pose(after_pose),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The watchdog counts cycles in which no transaction completes on any
  // channel; a hang ends the run with the fail verdict.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else if (!rst)
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // The result side holds ready low for a random stall before each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      out_ready <= 1'b0;
      repeat (stall) @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Sends one command and holds it until the block takes it.
  task automatic send_command(logic [1:0] m, logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [15:0] h, logic [51:0] t, logic [51:0] q,
                              logic [23:0] lim, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    repeat (gap) @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    pose_x <= x;
    pose_y <= y;
    pose_heading <= h;
    pose_time <= t;
    query_time <= q;
    distance_limit <= lim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until every expected result has come, then lets the block settle
  // for as long as its slowest command may take.
  task automatic drain_results();
    while (pending_count != 0) @(negedge clk);
    repeat (DEPTH + 10) @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_command();
    int pick;
    logic [51:0] q;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // Offer a pose near the track; every so often a wild pose or a stale time.
      track_time = track_time + 52'($urandom_range(0, 400000));
      track_x = track_x + 24'(signed'($urandom_range(0, 80)) - 40);
      track_y = track_y + 24'(signed'($urandom_range(0, 80)) - 40);
      track_heading = track_heading + 16'(signed'($urandom_range(0, 800)) - 400);
      if ($urandom_range(0, 9) == 0)
        send_command(MODE_OFFER, 24'($urandom), 24'($urandom), 16'($urandom),
                     52'({$urandom, $urandom}), 52'({$urandom, $urandom}),
                     24'($urandom), 1'b0);
      else if ($urandom_range(0, 19) == 0)
        send_command(MODE_OFFER, track_x, track_y, track_heading,
                     52'($urandom_range(0, 1200000)), 52'($urandom), 24'($urandom), 1'b0);
      else
        send_command(MODE_OFFER, track_x, track_y, track_heading, track_time,
                     52'({$urandom, $urandom}), 24'($urandom), 1'b0);
    end else if (pick < 75) begin
      q = (track_time > 52'd20000000) ? track_time - 52'($urandom_range(0, 20000000))
                                      : 52'($urandom_range(0, 30000000));
      if ($urandom_range(0, 7) == 0) q = 52'({$urandom, $urandom});
      send_command(MODE_BRACKET, 24'($urandom), 24'($urandom), 16'($urandom),
                   52'({$urandom, $urandom}), q, 24'($urandom), 1'b0);
    end else if (pick < 96) begin
      send_command(MODE_FIND, track_x + 24'(signed'($urandom_range(0, 400)) - 200),
                   track_y + 24'(signed'($urandom_range(0, 400)) - 200), 16'($urandom),
                   52'({$urandom, $urandom}), 52'({$urandom, $urandom}),
                   ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                               : 24'($urandom_range(0, 600)), 1'b0);
    end else begin
      send_command(MODE_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom),
                   52'({$urandom, $urandom}), 52'({$urandom, $urandom}),
                   24'($urandom), 1'b0);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_DIST;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_OFFER;
    pose_x = '0;
    pose_y = '0;
    pose_heading = '0;
    pose_time = '0;
    query_time = '0;
    distance_limit = '0;
    track_time = 52'd2000000;
    track_x = '0;
    track_y = '0;
    track_heading = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: queries on the empty ring, then offers at the extremes.
    send_command(MODE_BRACKET, '0, '0, '0, '0, 52'd5, '0, 1'b0);
    send_command(MODE_FIND, '0, '0, '0, '0, '0, '0, 1'b0);
    send_command(MODE_OFFER, 24'sd5, 24'sd5, 16'sd1, 52'd999999, '0, '0, 1'b0);
    send_command(MODE_OFFER, 24'sh800000, 24'sh7fffff, 16'sh8000, 52'd1000000, '0, '0, 1'b1);
    send_command(MODE_OFFER, 24'sh7fffff, 24'sh800000, 16'sh7fff, 52'd3000000, '0, '0, 1'b1);
    send_command(MODE_OFFER, 24'sd0, 24'sd0, 16'sd0, 52'd4000000, '0, '0, 1'b0);
    // Near duplicate is dropped; an earlier time never counts as a gap.
    send_command(MODE_OFFER, 24'sd1, 24'sd1, 16'sd1, 52'd4000001, '0, '0, 1'b0);
    send_command(MODE_OFFER, 24'sd2, 24'sd0, 16'sd0, 52'd2000000, '0, '0, 1'b0);
    // Heading wrap across the half turn, and a long time gap.
    send_command(MODE_OFFER, 24'sd0, 24'sd0, 16'sh7f00, 52'd4500000, '0, '0, 1'b0);
    send_command(MODE_OFFER, 24'sd0, 24'sd0, 16'sh8100, 52'd4600000, '0, '0, 1'b0);
    send_command(MODE_OFFER, 24'sd0, 24'sd0, 16'sh8100, 52'hfffffffffffff, '0, '0, 1'b0);
    send_command(MODE_OFFER, 24'sd0, 24'sd0, 16'sh8100, 52'd5000000, '0, '0, 1'b0);
    // Brackets: at the newest keyframe time, inside the history twice, miss.
    send_command(MODE_BRACKET, '0, '0, '0, '0, 52'hfffffffffffff, '0, 1'b0);
    send_command(MODE_BRACKET, '0, '0, '0, '0, 52'd4700000, '0, 1'b0);
    send_command(MODE_BRACKET, '0, '0, '0, '0, 52'd3500000, '0, 1'b0);
    send_command(MODE_BRACKET, '0, '0, '0, '0, 52'd0, '0, 1'b0);
    // Finds: limit zero, limit at the top, reference at the extremes.
    send_command(MODE_FIND, 24'sd0, 24'sd0, '0, '0, '0, 24'd0, 1'b0);
    send_command(MODE_FIND, 24'sh800000, 24'sh800000, '0, '0, '0, 24'hffffff, 1'b0);
    send_command(MODE_FIND, 24'sh7fffff, 24'sh7fffff, '0, '0, '0, 24'd100, 1'b0);
    // Clear keeps the latest pose, which a bracket then returns.
    send_command(MODE_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0);
    send_command(MODE_BRACKET, '0, '0, '0, '0, 52'd7, '0, 1'b0);
    send_command(MODE_FIND, '0, '0, '0, '0, '0, 24'd1, 1'b0);

    // Random part in phases with different thresholds, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: begin
          write_register(REG_DIST, 32'd0);
          write_register(REG_HEADING, 32'd0);
          write_register(REG_TIME, 32'd0);
        end
        2: begin
          write_register(REG_DIST, 32'hffffff);
          write_register(REG_HEADING, 32'd32768);
          write_register(REG_TIME, 32'hffffffff);
        end
        3: begin
          write_register(REG_DIST, 32'($urandom_range(10, 200)));
          write_register(REG_HEADING, 32'($urandom_range(50, 1000)));
          write_register(REG_TIME, 32'($urandom_range(100000, 2000000)));
        end
        4: begin
          write_register(REG_DIST, $urandom);
          write_register(REG_HEADING, $urandom);
          write_register(REG_TIME, $urandom);
        end
        default: begin
          write_register(REG_DIST, 32'd30);
          write_register(REG_HEADING, 32'd182);
          write_register(REG_TIME, 32'd10000000);
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        // Once per phase the sender holds back until all results are in.
        if (n == 50) while (pending_count != 0) @(negedge clk);
        send_random_command();
      end
    end

    drain_results();
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
